[rtl/lobm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int ID_W     = 31;
  localparam int QTY_W    = 31;
  localparam int PRICE_W  = 16;
  localparam int TPRICE_W = 10;
  localparam int COUNT_W  = 6;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_CANCEL = 1'b1
  } op_e;

  typedef enum logic {
    KIND_TRADE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_INVALID    = 3'd1,
    ST_PRICE_HIGH = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_CANCELLED  = 3'd4,
    ST_UNKNOWN    = 3'd5,
    ST_DROPPED    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    V_CHECK   = 2'd0,
    V_INVALID = 2'd1,
    V_HIGH    = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_MATCH,
    S_M_HEAD,
    S_M_FILL,
    S_UL_RD,
    S_UL_WR,
    S_RELEASE,
    S_ADV_RD,
    S_ADV_CK,
    S_REST_CHK,
    S_REST_WR,
    S_REST_LINK,
    S_STATUS
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [ID_W-1:0]    oid;
    logic               side;
    logic [PRICE_W-1:0] limit_price;
    logic [QTY_W-1:0]   order_quantity;
  } in_t;

  typedef struct packed {
    kind_e               kind;
    logic [ID_W-1:0]     buyer_id;
    logic [ID_W-1:0]     seller_id;
    logic [TPRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]    trade_quantity;
    status_e             status;
    logic [COUNT_W-1:0]  resting_orders;
    logic                last;
  } out_t;

  typedef struct packed {
    in_t      item;
    verdict_e verdict;
  } cmd_t;

endpackage

[rtl/lobm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lobm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_front
// Accepts input items, classifies their fields and queues them for the engine.
// ----------------------------------------------------------------------------
module lobm_front #(
  parameter int PRICE_CAP = 1023
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  input  lobm_pkg::in_t     in_data_i,
  output logic              in_stall_o,
  output logic              cmd_vld_o,
  output lobm_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  lobm_pkg::cmd_t     fifo_q [2];
  logic               wr_q, wr_d, rd_q, rd_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               push;
  lobm_pkg::cmd_t     cmd_new;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_vld_i && !in_stall_o;
  assign cmd_vld_o  = (cnt_q != 2'd0);
  assign cmd_o      = fifo_q[rd_q];

  always_comb begin
    cmd_new.item = in_data_i;
    if (in_data_i.operation == lobm_pkg::OP_CANCEL) begin
      cmd_new.verdict = lobm_pkg::V_CHECK;
    end else if (in_data_i.oid == '0 || in_data_i.limit_price == '0 ||
                 in_data_i.order_quantity == '0) begin
      cmd_new.verdict = lobm_pkg::V_INVALID;
    end else if (32'(in_data_i.limit_price) > 32'(PRICE_CAP)) begin
      cmd_new.verdict = lobm_pkg::V_HIGH;
    end else begin
      cmd_new.verdict = lobm_pkg::V_CHECK;
    end
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = !wr_q;
    end
    if (cmd_pop_i && cmd_vld_o) begin
      rd_d = !rd_q;
    end
    case ({push, cmd_pop_i && cmd_vld_o})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_new;
    end
  end

endmodule

[rtl/lobm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_back
// Order book engine: id search, matching, unlinking, resting and cursor scans.
// ----------------------------------------------------------------------------
module lobm_back #(
  parameter int PRICE_CAP   = 1023,
  parameter int ORDER_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_vld_i,
  input  lobm_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              out_vld_o,
  output lobm_pkg::out_t    out_data_o,
  input  logic              out_stall_i
);

  localparam int LEVELS = PRICE_CAP + 1;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int SLOT_W = $clog2(ORDER_SLOTS + 1);
  localparam int IDX_W  = $clog2(ORDER_SLOTS);
  localparam int ID_W   = lobm_pkg::ID_W;
  localparam int QTY_W  = lobm_pkg::QTY_W;
  localparam int INFO_W = ID_W + LVL_W + QTY_W + 1;
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(ORDER_SLOTS);

  lobm_pkg::state_e   state_q, state_d;
  logic [LVL_W-1:0]   clr_q, clr_d;
  lobm_pkg::op_e      op_q, op_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic               side_q, side_d;
  logic [LVL_W-1:0]   price_q, price_d;
  logic [QTY_W-1:0]   qty_q, qty_d;
  lobm_pkg::status_e  status_q, status_d;
  logic [IDX_W-1:0]   scan_q, scan_d, chk_idx_q, chk_idx_d;
  logic               chk_vld_q, chk_vld_d;
  logic [SLOT_W-1:0]  slot_q, slot_d, p_q, p_d;
  logic [LVL_W-1:0]   lv_q, lv_d;
  logic               adv_ask_q, adv_ask_d;
  logic [LVL_W-1:0]   bid_q, bid_d, ask_q, ask_d;
  logic               bid_none_q, bid_none_d, ask_none_q, ask_none_d;
  logic [SLOT_W-1:0]  free_q, free_d, fresh_q, fresh_d, rest_q, rest_d;
  logic [ORDER_SLOTS-1:0] live_q, live_d;
  logic               out_vld_q, out_vld_d;
  lobm_pkg::out_t     out_q, out_d;

  logic               head_we, tail_we, info_we, prev_we, next_we;
  logic [LVL_W-1:0]   head_waddr, head_raddr, tail_waddr, tail_raddr;
  logic [SLOT_W-1:0]  head_wdata, head_rdata, tail_wdata, tail_rdata;
  logic [IDX_W-1:0]   info_waddr, info_raddr, prev_waddr, prev_raddr;
  logic [IDX_W-1:0]   next_waddr, next_raddr;
  logic [INFO_W-1:0]  info_wdata, info_rdata;
  logic [SLOT_W-1:0]  prev_wdata, prev_rdata, next_wdata, next_rdata;

  logic [ID_W-1:0]    rd_id;
  logic [LVL_W-1:0]   rd_price;
  logic [QTY_W-1:0]   rd_qty, fill;
  logic               rd_side, can_load, adv_none;

  assign rd_id    = info_rdata[INFO_W-1 -: ID_W];
  assign rd_price = info_rdata[QTY_W+1 +: LVL_W];
  assign rd_qty   = info_rdata[1 +: QTY_W];
  assign rd_side  = info_rdata[0];
  assign fill     = (qty_q < rd_qty) ? qty_q : rd_qty;
  assign can_load = !out_vld_q || !out_stall_i;
  assign adv_none = adv_ask_q ? ask_none_q : bid_none_q;

  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

  lobm_ram #(.WIDTH(SLOT_W), .DEPTH(LEVELS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  lobm_ram #(.WIDTH(SLOT_W), .DEPTH(LEVELS)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_waddr), .wdata_i(tail_wdata),
    .raddr_i(tail_raddr), .rdata_o(tail_rdata)
  );
  lobm_ram #(.WIDTH(INFO_W), .DEPTH(ORDER_SLOTS)) u_info (
    .clk_i, .we_i(info_we), .waddr_i(info_waddr), .wdata_i(info_wdata),
    .raddr_i(info_raddr), .rdata_o(info_rdata)
  );
  lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .raddr_i(prev_raddr), .rdata_o(prev_rdata)
  );
  lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(next_raddr), .rdata_o(next_rdata)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    op_d       = op_q;
    id_d       = id_q;
    side_d     = side_q;
    price_d    = price_q;
    qty_d      = qty_q;
    status_d   = status_q;
    scan_d     = scan_q;
    chk_idx_d  = chk_idx_q;
    chk_vld_d  = chk_vld_q;
    slot_d     = slot_q;
    p_d        = p_q;
    lv_d       = lv_q;
    adv_ask_d  = adv_ask_q;
    bid_d      = bid_q;
    ask_d      = ask_q;
    bid_none_d = bid_none_q;
    ask_none_d = ask_none_q;
    free_d     = free_q;
    fresh_d    = fresh_q;
    rest_d     = rest_q;
    live_d     = live_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    cmd_pop_o  = 1'b0;
    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    head_raddr = '0;
    tail_we    = 1'b0;
    tail_waddr = '0;
    tail_wdata = '0;
    tail_raddr = '0;
    info_we    = 1'b0;
    info_waddr = '0;
    info_wdata = '0;
    info_raddr = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    prev_raddr = '0;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    next_raddr = '0;

    case (state_q)
      lobm_pkg::S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = NO_SLOT;
        tail_we    = 1'b1;
        tail_waddr = clr_q;
        tail_wdata = NO_SLOT;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LVL_W'(PRICE_CAP)) begin
          state_d = lobm_pkg::S_IDLE;
        end
      end
      lobm_pkg::S_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.item.operation;
          id_d      = cmd_i.item.oid;
          side_d    = cmd_i.item.side;
          price_d   = cmd_i.item.limit_price[LVL_W-1:0];
          qty_d     = cmd_i.item.order_quantity;
          case (cmd_i.verdict)
            lobm_pkg::V_INVALID: begin
              status_d = lobm_pkg::ST_INVALID;
              state_d  = lobm_pkg::S_STATUS;
            end
            lobm_pkg::V_HIGH: begin
              status_d = lobm_pkg::ST_PRICE_HIGH;
              state_d  = lobm_pkg::S_STATUS;
            end
            default: begin
              scan_d    = '0;
              chk_vld_d = 1'b0;
              state_d   = lobm_pkg::S_FIND;
            end
          endcase
        end
      end
      lobm_pkg::S_FIND: begin
        info_raddr = scan_q;
        chk_idx_d  = scan_q;
        chk_vld_d  = 1'b1;
        scan_d     = scan_q + 1'b1;
        if (chk_vld_q) begin
          if (live_q[chk_idx_q] && rd_id == id_q) begin
            if (op_q == lobm_pkg::OP_CANCEL) begin
              slot_d  = SLOT_W'(chk_idx_q);
              lv_d    = rd_price;
              side_d  = rd_side;
              state_d = lobm_pkg::S_UL_RD;
            end else begin
              status_d = lobm_pkg::ST_DUPLICATE;
              state_d  = lobm_pkg::S_STATUS;
            end
          end else if (chk_idx_q == IDX_W'(ORDER_SLOTS - 1)) begin
            if (op_q == lobm_pkg::OP_CANCEL) begin
              status_d = lobm_pkg::ST_UNKNOWN;
              state_d  = lobm_pkg::S_STATUS;
            end else begin
              state_d = lobm_pkg::S_MATCH;
            end
          end
        end
      end
      lobm_pkg::S_MATCH: begin
        if (qty_q == '0) begin
          state_d = lobm_pkg::S_REST_CHK;
        end else if (side_q) begin
          if (bid_none_q || bid_q < price_q) begin
            state_d = lobm_pkg::S_REST_CHK;
          end else begin
            lv_d       = bid_q;
            head_raddr = bid_q;
            state_d    = lobm_pkg::S_M_HEAD;
          end
        end else begin
          if (ask_none_q || ask_q > price_q) begin
            state_d = lobm_pkg::S_REST_CHK;
          end else begin
            lv_d       = ask_q;
            head_raddr = ask_q;
            state_d    = lobm_pkg::S_M_HEAD;
          end
        end
      end
      lobm_pkg::S_M_HEAD: begin
        if (head_rdata == NO_SLOT) begin
          adv_ask_d = !side_q;
          state_d   = lobm_pkg::S_ADV_RD;
        end else begin
          slot_d     = head_rdata;
          info_raddr = head_rdata[IDX_W-1:0];
          state_d    = lobm_pkg::S_M_FILL;
        end
      end
      lobm_pkg::S_M_FILL: begin
        info_raddr = slot_q[IDX_W-1:0];
        if (can_load) begin
          out_vld_d            = 1'b1;
          out_d.kind           = lobm_pkg::KIND_TRADE;
          out_d.buyer_id       = side_q ? rd_id : id_q;
          out_d.seller_id      = side_q ? id_q : rd_id;
          out_d.trade_price    = lobm_pkg::TPRICE_W'(lv_q);
          out_d.trade_quantity = fill;
          out_d.status         = lobm_pkg::ST_ADDED;
          out_d.resting_orders = '0;
          out_d.last           = 1'b0;
          qty_d                = qty_q - fill;
          info_we              = 1'b1;
          info_waddr           = slot_q[IDX_W-1:0];
          info_wdata           = {rd_id, rd_price, rd_qty - fill, rd_side};
          state_d = (rd_qty == fill) ? lobm_pkg::S_UL_RD : lobm_pkg::S_MATCH;
        end
      end
      lobm_pkg::S_UL_RD: begin
        prev_raddr = slot_q[IDX_W-1:0];
        next_raddr = slot_q[IDX_W-1:0];
        state_d    = lobm_pkg::S_UL_WR;
      end
      lobm_pkg::S_UL_WR: begin
        if (prev_rdata != NO_SLOT) begin
          next_we    = 1'b1;
          next_waddr = prev_rdata[IDX_W-1:0];
          next_wdata = next_rdata;
        end else begin
          head_we    = 1'b1;
          head_waddr = lv_q;
          head_wdata = next_rdata;
        end
        if (next_rdata != NO_SLOT) begin
          prev_we    = 1'b1;
          prev_waddr = next_rdata[IDX_W-1:0];
          prev_wdata = prev_rdata;
        end else begin
          tail_we    = 1'b1;
          tail_waddr = lv_q;
          tail_wdata = prev_rdata;
        end
        state_d = lobm_pkg::S_RELEASE;
      end
      lobm_pkg::S_RELEASE: begin
        live_d[slot_q[IDX_W-1:0]] = 1'b0;
        next_we    = 1'b1;
        next_waddr = slot_q[IDX_W-1:0];
        next_wdata = free_q;
        free_d     = slot_q;
        if (rest_q != '0) begin
          rest_d = rest_q - 1'b1;
        end
        adv_ask_d = (op_q == lobm_pkg::OP_CANCEL) ? side_q : !side_q;
        state_d   = lobm_pkg::S_ADV_RD;
      end
      lobm_pkg::S_ADV_RD: begin
        if (adv_none) begin
          if (op_q == lobm_pkg::OP_CANCEL) begin
            status_d = lobm_pkg::ST_CANCELLED;
            state_d  = lobm_pkg::S_STATUS;
          end else begin
            state_d = lobm_pkg::S_MATCH;
          end
        end else begin
          head_raddr = adv_ask_q ? ask_q : bid_q;
          state_d    = lobm_pkg::S_ADV_CK;
        end
      end
      lobm_pkg::S_ADV_CK: begin
        if (head_rdata == NO_SLOT) begin
          if (adv_ask_q) begin
            if (ask_q == LVL_W'(PRICE_CAP)) begin
              ask_none_d = 1'b1;
            end else begin
              ask_d = ask_q + 1'b1;
            end
          end else begin
            if (bid_q == '0) begin
              bid_none_d = 1'b1;
            end else begin
              bid_d = bid_q - 1'b1;
            end
          end
          state_d = lobm_pkg::S_ADV_RD;
        end else if (op_q == lobm_pkg::OP_CANCEL) begin
          status_d = lobm_pkg::ST_CANCELLED;
          state_d  = lobm_pkg::S_STATUS;
        end else begin
          state_d = lobm_pkg::S_MATCH;
        end
      end
      lobm_pkg::S_REST_CHK: begin
        next_raddr = free_q[IDX_W-1:0];
        tail_raddr = price_q;
        if (qty_q == '0) begin
          status_d = lobm_pkg::ST_ADDED;
          state_d  = lobm_pkg::S_STATUS;
        end else if (free_q != NO_SLOT) begin
          slot_d  = free_q;
          state_d = lobm_pkg::S_REST_WR;
        end else if (fresh_q < NO_SLOT) begin
          slot_d  = fresh_q;
          fresh_d = fresh_q + 1'b1;
          state_d = lobm_pkg::S_REST_WR;
        end else begin
          status_d = lobm_pkg::ST_DROPPED;
          state_d  = lobm_pkg::S_STATUS;
        end
      end
      lobm_pkg::S_REST_WR: begin
        info_we    = 1'b1;
        info_waddr = slot_q[IDX_W-1:0];
        info_wdata = {id_q, price_q, qty_q, side_q};
        prev_we    = 1'b1;
        prev_waddr = slot_q[IDX_W-1:0];
        prev_wdata = tail_rdata;
        next_we    = 1'b1;
        next_waddr = slot_q[IDX_W-1:0];
        next_wdata = NO_SLOT;
        tail_we    = 1'b1;
        tail_waddr = price_q;
        tail_wdata = slot_q;
        if (tail_rdata == NO_SLOT) begin
          head_we    = 1'b1;
          head_waddr = price_q;
          head_wdata = slot_q;
        end
        p_d = tail_rdata;
        if (slot_q == free_q) begin
          free_d = next_rdata;
        end
        live_d[slot_q[IDX_W-1:0]] = 1'b1;
        rest_d = rest_q + 1'b1;
        if (side_q) begin
          if (ask_none_q || price_q < ask_q) begin
            ask_d      = price_q;
            ask_none_d = 1'b0;
          end
        end else begin
          if (bid_none_q || price_q > bid_q) begin
            bid_d      = price_q;
            bid_none_d = 1'b0;
          end
        end
        state_d = lobm_pkg::S_REST_LINK;
      end
      lobm_pkg::S_REST_LINK: begin
        if (p_q != NO_SLOT) begin
          next_we    = 1'b1;
          next_waddr = p_q[IDX_W-1:0];
          next_wdata = slot_q;
        end
        status_d = lobm_pkg::ST_ADDED;
        state_d  = lobm_pkg::S_STATUS;
      end
      lobm_pkg::S_STATUS: begin
        if (can_load) begin
          out_vld_d            = 1'b1;
          out_d.kind           = lobm_pkg::KIND_STATUS;
          out_d.buyer_id       = '0;
          out_d.seller_id      = '0;
          out_d.trade_price    = '0;
          out_d.trade_quantity = '0;
          out_d.status         = status_q;
          out_d.resting_orders = lobm_pkg::COUNT_W'(rest_q);
          out_d.last           = 1'b1;
          state_d              = lobm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lobm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lobm_pkg::S_CLEAR;
      clr_q      <= '0;
      chk_vld_q  <= 1'b0;
      bid_q      <= '0;
      ask_q      <= '0;
      bid_none_q <= 1'b1;
      ask_none_q <= 1'b1;
      free_q     <= NO_SLOT;
      fresh_q    <= '0;
      rest_q     <= '0;
      live_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      chk_vld_q  <= chk_vld_d;
      bid_q      <= bid_d;
      ask_q      <= ask_d;
      bid_none_q <= bid_none_d;
      ask_none_q <= ask_none_d;
      free_q     <= free_d;
      fresh_q    <= fresh_d;
      rest_q     <= rest_d;
      live_q     <= live_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    side_q    <= side_d;
    price_q   <= price_d;
    qty_q     <= qty_d;
    status_q  <= status_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    slot_q    <= slot_d;
    p_q       <= p_d;
    lv_q      <= lv_d;
    adv_ask_q <= adv_ask_d;
    out_q     <= out_d;
  end

endmodule

[rtl/limit_order_book_matcher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority limit order book with a fixed pool of order slots.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the price level memory once, one level per
// cycle, and takes no order until that sweep is done; up to two items are
// queued meanwhile. An add with a zero field or a price above PRICE_CAP goes
// straight to its status without a search. Every other item is taken and
// searches the slot memory for its id. An add then trades against the head
// order of each crossing level, unlinks and releases a resting order that a
// trade empties, and rests any remainder in a free slot, if there is one.
// A cancel that finds its order unlinks it and checks the cursor. The best
// bid or ask cursor steps over empty price levels one level at a time, and
// each item ends with a status transfer.
// The engine handles one item at a time and its results leave through an
// output register; while a result waits, the front queues up to two further
// items and then stalls its input.
module limit_order_book_matcher_unit #(
  parameter int PRICE_CAP   = 1023,
  parameter int ORDER_SLOTS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  input  lobm_pkg::in_t   in_data_i,
  output logic            in_stall_o,
  output logic            out_vld_o,
  output lobm_pkg::out_t  out_data_o,
  input  logic            out_stall_i
);

  logic           cmd_vld, cmd_pop;
  lobm_pkg::cmd_t cmd;

  lobm_front #(.PRICE_CAP(PRICE_CAP)) u_front (
    .clk_i, .rst_ni, .in_vld_i, .in_data_i, .in_stall_o,
    .cmd_vld_o(cmd_vld), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  lobm_back #(.PRICE_CAP(PRICE_CAP), .ORDER_SLOTS(ORDER_SLOTS)) u_back (
    .clk_i, .rst_ni, .cmd_vld_i(cmd_vld), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .out_vld_o, .out_data_o, .out_stall_i
  );

endmodule
